// ===== rtl/tis_pkg.sv =====
// Shared types and constants for the timestamp index seek block.
// No dependencies; every other file imports this package.
`default_nettype none
package tis_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int MODE_W   = 2;
  localparam int STAMP_W  = 64;
  localparam int OFFSET_W = 48;
  localparam int BYTES_W  = 29;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 12;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic                keyframe;
    logic [OFFSET_W-1:0] offset;
    logic [BYTES_W-1:0]  bytes;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/tis_req_if.sv =====
// Request channel of the timestamp index seek block: valid/ready plus one item.
// Depends on tis_pkg for field widths.
`default_nettype none
interface tis_req_if import tis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [STAMP_W-1:0]  stamp;
  logic                entry_keyframe;
  logic [OFFSET_W-1:0] entry_offset;
  logic [BYTES_W-1:0]  entry_bytes;
  logic                keyframe_only_flag;

  modport source (output valid, mode, stamp, entry_keyframe, entry_offset, entry_bytes,
                  keyframe_only_flag, input ready);
  modport sink (input valid, mode, stamp, entry_keyframe, entry_offset, entry_bytes,
                keyframe_only_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/tis_rsp_if.sv =====
// Response channel of the timestamp index seek block: valid/ready plus one item.
// Depends on tis_pkg for field widths.
`default_nettype none
interface tis_rsp_if import tis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    hit_position;
  logic [STAMP_W-1:0]  hit_stamp;
  logic                hit_keyframe;
  logic [OFFSET_W-1:0] hit_offset;
  logic [BYTES_W-1:0]  hit_bytes;

  modport source (output valid, status, hit_position, hit_stamp, hit_keyframe, hit_offset,
                  hit_bytes, input ready);
  modport sink (input valid, status, hit_position, hit_stamp, hit_keyframe, hit_offset,
                hit_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/timestamp_index_seek.sv =====
// Top level of the timestamp index seek block: entry table memory and sequencer.
// Depends on tis_pkg, tis_req_if and tis_rsp_if.
//
// Usage: items arrive on req (valid/ready). mode selects clear, append or
// query. Every item yields exactly one item on rsp, in order.
// The block takes one item at a time: req.ready is high only while the
// sequencer is idle. A result sits in the rsp output register until taken,
// and the next item is accepted meanwhile; its own result waits in the
// sequencer until the output register frees up, so a stalled receiver
// back-pressures req after at most one more item.
// A query reads the first entry, then runs at most ceil(log2 N) binary search
// steps over N stored entries, then reads at least one entry during keyframe
// walk-back (one entry when no walk is needed). Clear, append and undefined
// modes go straight to the result. All table reads go through the single
// registered read port of the entry memory. A query whose stamp is below the
// first entry returns without a search; an empty table returns without a
// read. req.ready rises together with rsp.valid.
// Reset (synchronous, rst high) empties the table and drops any pending
// result; memory contents are not cleared and no clearing pass is run.
`default_nettype none
module timestamp_index_seek import tis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  tis_req_if.sink   req,
  tis_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST_RD,
    S_FIRST_CHK,
    S_SEARCH,
    S_MID_RD,
    S_MID_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_RESULT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    total;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [ADDR_W-1:0]   addr;
  logic [STAMP_W-1:0]  q_stamp;
  logic                q_kf_only;
  logic [STATUS_W-1:0] pend_status;
  logic [POS_W-1:0]    pend_pos;
  entry_t              pend_entry;

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_data;
  entry_t              wr_entry;
  logic                mem_we;
  logic                mem_re;

  logic                accept;
  logic                full;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    mid;
  logic                out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (total >= CNT_W'(TABLE_DEPTH));
  assign span      = hi - lo;
  assign mid       = lo + (span >> 1);
  assign out_free  = !rsp.valid || rsp.ready;

  assign wr_entry.stamp    = req.stamp;
  assign wr_entry.keyframe = req.entry_keyframe;
  assign wr_entry.offset   = req.entry_offset;
  assign wr_entry.bytes    = req.entry_bytes;

  assign mem_we = accept && (req.mode == MODE_APPEND) && !full;
  assign mem_re = (state == S_FIRST_RD) || (state == S_MID_RD) || (state == S_WALK_RD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[total[ADDR_W-1:0]] <= wr_entry;
    end
    if (mem_re) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // S_RESULT reloads the output register itself
      if (rsp.valid && rsp.ready && (state != S_RESULT)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            q_stamp     <= req.stamp;
            q_kf_only   <= req.keyframe_only_flag;
            pend_pos    <= '0;
            pend_entry  <= '0;
            priority if (req.mode == MODE_CLEAR) begin
              total       <= '0;
              pend_status <= ST_OK;
              state       <= S_RESULT;
            end else if (req.mode == MODE_APPEND) begin
              state <= S_RESULT;
              if (full) begin
                pend_status <= ST_FULL;
              end else begin
                total       <= total + CNT_W'(1);
                pend_status <= ST_OK;
              end
            end else if (req.mode == MODE_QUERY) begin
              pend_status <= ST_NOT_FOUND;
              if (total != '0) begin
                addr  <= '0;
                lo    <= '0;
                hi    <= total;
                state <= S_FIRST_RD;
              end else begin
                state <= S_RESULT;
              end
            end else begin
              // undefined mode: not-found with empty fields
              pend_status <= ST_NOT_FOUND;
              state       <= S_RESULT;
            end
          end
        end
        S_FIRST_RD: begin
          state <= S_FIRST_CHK;
        end
        S_FIRST_CHK: begin
          if (q_stamp < rd_data.stamp) begin
            state <= S_RESULT;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (span > CNT_W'(1)) begin
            addr  <= mid[ADDR_W-1:0];
            state <= S_MID_RD;
          end else begin
            addr  <= lo[ADDR_W-1:0];
            state <= S_WALK_RD;
          end
        end
        S_MID_RD: begin
          state <= S_MID_CHK;
        end
        S_MID_CHK: begin
          if (rd_data.stamp <= q_stamp) begin
            lo <= CNT_W'(addr);
          end else begin
            hi <= CNT_W'(addr);
          end
          state <= S_SEARCH;
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (!q_kf_only || rd_data.keyframe) begin
            pend_status <= ST_OK;
            pend_pos    <= POS_W'(lo);
            pend_entry  <= rd_data;
            state       <= S_RESULT;
          end else if (lo == '0) begin
            state <= S_RESULT;
          end else begin
            lo    <= lo - CNT_W'(1);
            addr  <= addr - ADDR_W'(1);
            state <= S_WALK_RD;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= pend_status;
            rsp.hit_position <= pend_pos;
            rsp.hit_stamp    <= pend_entry.stamp;
            rsp.hit_keyframe <= pend_entry.keyframe;
            rsp.hit_offset   <= pend_entry.offset;
            rsp.hit_bytes    <= pend_entry.bytes;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo < hi) && (hi <= total))
    else $error("search window empty or beyond table");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while previous item still in work");

endmodule
`default_nettype wire
